// ===== hdl/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// hts_pkg
// shared widths, register indexes, reset values and unit status types for the
// hub timestamp converter
// ----------------------------------------------------------------------------
package hts_pkg;

  // field widths
  localparam int TICK_W    = 32;
  localparam int RES_W     = 20;
  localparam int SLEW_W    = 20;
  localparam int MARGIN_W  = 30;
  localparam int HOST_W    = 63;
  localparam int TS_W      = 64;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;

  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 2'd2;

  localparam logic [RES_W-1:0]    RESET_RESOLUTION = 20'd100000;
  localparam logic [SLEW_W-1:0]   RESET_SLEW       = 20'd50000;
  localparam logic [MARGIN_W-1:0] RESET_MARGIN     = 30'd20000000;

  // shared multiplier: 33-bit magnitude times 20-bit operand
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 20;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // constant divider: 52-bit magnitude by ns per ms, four quotient bits a pass
  localparam int DIV_W     = 52;
  localparam int DIV_REM_W = 20;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int QUOT_W    = 33;

  localparam logic [DIV_REM_W-1:0] NS_PER_MS = 20'd1000000;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/hub_timestamp_offset_slew.sv =====
// ----------------------------------------------------------------------------
// hub_timestamp_offset_slew
// maps sensor hub tick counts to host ns timestamps with a slewed offset
// ----------------------------------------------------------------------------
// sequencing: an accepted item holds the block until it is done, so a new item
//   is taken only in idle; the work is three passes through the shared
//   multiplier and the 13 passes of the divider by ns per ms, and a convert
//   result can wait for a free output register
// reset: synchronous active-low rst_n clears sync state and the output valid,
//   and loads the configuration registers with their reset values
module hub_timestamp_offset_slew (
  input  logic                              clk,
  input  logic                              rst_n,

  // configuration write channel, always ready
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hts_pkg::CFG_DATA_W-1:0]    cfg_data,

  // input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [hts_pkg::TICK_W-1:0]        in_hub_ticks,
  input  logic [hts_pkg::HOST_W-1:0]        in_host_time_ns,
  input  logic                              in_reset_offset,

  // result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [hts_pkg::TS_W-1:0]   out_timestamp_ns
);

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HUB   = 4'd1;  // multiply ticks by resolution
  localparam logic [3:0] S_ELAP  = 4'd2;  // multiply elapsed ticks by resolution
  localparam logic [3:0] S_DLOAD = 4'd3;  // start the ms divider
  localparam logic [3:0] S_DIV   = 4'd4;  // wait for the divider
  localparam logic [3:0] S_STEP  = 4'd5;  // multiply ms by slew rate
  localparam logic [3:0] S_CAND  = 4'd6;  // candidate offset
  localparam logic [3:0] S_CLAMP = 4'd7;  // clamp between current and target
  localparam logic [3:0] S_FIN   = 4'd8;  // emit result or update sync state

  localparam logic KIND_CONVERT = 1'b0;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // configuration registers
  logic [hts_pkg::RES_W-1:0]    res_r;
  logic [hts_pkg::SLEW_W-1:0]   slew_r;
  logic [hts_pkg::MARGIN_W-1:0] margin_r;

  // sync state
  logic                         synced_r;
  logic [hts_pkg::TICK_W-1:0]   sync_ticks_r;
  logic [hts_pkg::TS_W-1:0]     cur_r;
  logic [hts_pkg::TS_W-1:0]     tgt_r;

  // latched item
  logic                         kind_r;
  logic [hts_pkg::TICK_W-1:0]   ticks_r;
  logic [hts_pkg::HOST_W-1:0]   host_r;
  logic                         jump_r;

  // working registers
  logic [hts_pkg::MUL_P_W-1:0]  hub_ns_r;
  logic                         neg_r;
  logic                         ge_r;
  logic [hts_pkg::TS_W-1:0]     cand_r;
  logic [hts_pkg::TS_W-1:0]     kept_r;

  // output register
  logic                         out_valid_r;
  logic [hts_pkg::TS_W-1:0]     out_ts_r;

  // shared units
  logic [hts_pkg::MUL_A_W-1:0]  mul_a;
  logic [hts_pkg::MUL_B_W-1:0]  mul_b;
  logic [hts_pkg::MUL_P_W-1:0]  prod;
  logic                         div_start;
  hts_pkg::div_stat_t           div_stat;
  logic [hts_pkg::QUOT_W-1:0]   quot;

  // elapsed ticks as a signed 33-bit difference, split into sign and magnitude
  logic [hts_pkg::TICK_W:0]     diff;
  logic [hts_pkg::TICK_W:0]     diff_mag;

  logic [hts_pkg::TS_W-1:0]     step;
  logic [hts_pkg::TS_W-1:0]     hub64;
  logic [hts_pkg::TS_W-1:0]     new_tgt;
  logic                         out_free;
  logic                         accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  assign diff     = {1'b0, ticks_r} - {1'b0, sync_ticks_r};
  assign diff_mag = diff[hts_pkg::TICK_W] ? (~diff + 1'b1) : diff;

  // slew step carries the sign of the elapsed time
  assign step = neg_r ? (~hts_pkg::TS_W'(prod) + 1'b1) : hts_pkg::TS_W'(prod);

  assign hub64   = hts_pkg::TS_W'(hub_ns_r);
  assign new_tgt = {1'b0, host_r} - hub64 - hts_pkg::TS_W'(margin_r);

  // multiplier operand select by sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_HUB: begin
        mul_a = hts_pkg::MUL_A_W'(ticks_r);
        mul_b = res_r;
      end
      S_ELAP: begin
        mul_a = diff_mag;
        mul_b = res_r;
      end
      S_STEP: begin
        mul_a = quot;
        mul_b = slew_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start = (state_r == S_DLOAD);

  hts_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  hts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod[hts_pkg::DIV_W-1:0]),
    .stat     (div_stat),
    .quotient (quot)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_HUB;
      S_HUB:   state_nxt = S_ELAP;
      S_ELAP:  state_nxt = S_DLOAD;
      S_DLOAD: state_nxt = S_DIV;
      S_DIV:   if (div_stat.done) state_nxt = S_STEP;
      S_STEP:  state_nxt = S_CAND;
      S_CAND:  state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_FIN;
      S_FIN: begin
        // a convert result waits here only while the output register is full
        if (kind_r != KIND_CONVERT || out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_r        <= hts_pkg::RESET_RESOLUTION;
      slew_r       <= hts_pkg::RESET_SLEW;
      margin_r     <= hts_pkg::RESET_MARGIN;
      synced_r     <= 1'b0;
      sync_ticks_r <= '0;
      cur_r        <= '0;
      tgt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // configuration writes; index three is ignored
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          hts_pkg::REG_RESOLUTION: res_r    <= cfg_data[hts_pkg::RES_W-1:0];
          hts_pkg::REG_SLEW:       slew_r   <= cfg_data[hts_pkg::SLEW_W-1:0];
          hts_pkg::REG_MARGIN:     margin_r <= cfg_data[hts_pkg::MARGIN_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      if (state_r == S_FIN) begin
        if (kind_r == KIND_CONVERT) begin
          if (out_free) out_valid_r <= 1'b1;
        end else begin
          // sync item: new target, offset keeps the slew unless it jumps
          tgt_r        <= new_tgt;
          cur_r        <= (!synced_r || jump_r) ? new_tgt : kept_r;
          sync_ticks_r <= ticks_r;
          synced_r     <= (host_r != '0);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      ticks_r <= in_hub_ticks;
      host_r  <= in_host_time_ns;
      jump_r  <= in_reset_offset;
    end

    if (state_r == S_ELAP) begin
      hub_ns_r <= prod;
      neg_r    <= diff[hts_pkg::TICK_W];
    end

    if (state_r == S_CAND) begin
      ge_r   <= ($signed(tgt_r) >= $signed(cur_r));
      cand_r <= ($signed(tgt_r) >= $signed(cur_r)) ? (cur_r + step) : (cur_r - step);
    end

    // clamp compares the wrapped candidate as two's complement
    if (state_r == S_CLAMP) begin
      if (ge_r) begin
        priority if ($signed(cand_r) > $signed(tgt_r)) kept_r <= tgt_r;
        else if ($signed(cand_r) < $signed(cur_r))     kept_r <= cur_r;
        else                                           kept_r <= cand_r;
      end else begin
        priority if ($signed(cand_r) < $signed(tgt_r)) kept_r <= tgt_r;
        else if ($signed(cand_r) > $signed(cur_r))     kept_r <= cur_r;
        else                                           kept_r <= cand_r;
      end
    end

    if (state_r == S_FIN && kind_r == KIND_CONVERT && out_free) begin
      // while unsynced the host time less margin is passed through
      out_ts_r <= synced_r ? (hub64 + kept_r)
                           : ({1'b0, host_r} - hts_pkg::TS_W'(margin_r));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_timestamp_ns = $signed(out_ts_r);

endmodule

// ===== hdl/hts_mul.sv =====
// ----------------------------------------------------------------------------
// hts_mul
// shared unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
module hts_mul (
  input  logic                         clk,
  input  logic [hts_pkg::MUL_A_W-1:0]  a,
  input  logic [hts_pkg::MUL_B_W-1:0]  b,
  output logic [hts_pkg::MUL_P_W-1:0]  p
);

  logic [hts_pkg::MUL_P_W-1:0] p_r;
  logic [hts_pkg::MUL_P_W-1:0] p_nxt;

  assign p_nxt = hts_pkg::MUL_P_W'(a) * hts_pkg::MUL_P_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

// ===== hdl/hts_div.sv =====
// ----------------------------------------------------------------------------
// hts_div
// iterative restoring divider by ns per ms, four quotient bits per cycle
// ----------------------------------------------------------------------------
module hts_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [hts_pkg::DIV_W-1:0]     dividend,
  output hts_pkg::div_stat_t            stat,
  output logic [hts_pkg::QUOT_W-1:0]    quotient
);

  logic [hts_pkg::DIV_REM_W-1:0] rem_r;
  logic [hts_pkg::DIV_REM_W-1:0] rem_nxt;
  logic [hts_pkg::DIV_W-1:0]     dq_r;
  logic [hts_pkg::DIV_W-1:0]     dq_nxt;
  logic [hts_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;

  // shift-subtract passes over remainder and dividend/quotient register
  always_comb begin
    logic [hts_pkg::DIV_REM_W:0] trial;
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    for (int i = 0; i < hts_pkg::DIV_BITS; i++) begin
      trial  = {rem_nxt, dq_nxt[hts_pkg::DIV_W-1]};
      dq_nxt = {dq_nxt[hts_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, hts_pkg::NS_PER_MS}) begin
        rem_nxt   = hts_pkg::DIV_REM_W'(trial - {1'b0, hts_pkg::NS_PER_MS});
        dq_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[hts_pkg::DIV_REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == hts_pkg::DIV_CNT_W'(hts_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r[hts_pkg::QUOT_W-1:0];

endmodule

// ===== hdl/hts_checker.sv =====
// ----------------------------------------------------------------------------
// hts_checker
// port-level checks on the hub timestamp converter, bound to the top level
// ----------------------------------------------------------------------------
module hts_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_kind,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [hts_pkg::TS_W-1:0]   out_timestamp_ns
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_timestamp_ns))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high right after an accept");

  // no result appears the cycle after an accept with nothing pending
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early after accept");

  // a sync item accepted with nothing pending raises no result after the accept
  a_sync_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind && !out_valid |=> ##1 !out_valid)
    else $error("result after sync item");

  // reset clears the output valid
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind hub_timestamp_offset_slew hts_checker u_hts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_kind          (in_kind),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_timestamp_ns (out_timestamp_ns)
);

// ===== sim/hub_timestamp_offset_slew_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hub_timestamp_offset_slew_tb
// self-checking bench for the hub timestamp converter: items go in through a
// valid/ready channel, a predictor in the bench computes each expected
// timestamp, and every result is compared in order against it
// ----------------------------------------------------------------------------
module hub_timestamp_offset_slew_tb;
  import hts_pkg::*;

  // item kinds on in_kind
  typedef enum logic {
    KIND_CONVERT = 1'b0,
    KIND_SYNC    = 1'b1
  } item_kind_e;

  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // long enough to cover a sync item still in the sequencer
  localparam int DRAIN_CYCLES = 32;
  // receiver hold-off long enough to back the block up into in_ready
  localparam int HOLD_CYCLES  = 400;
  // hard stop time in ns
  localparam int RUN_LIMIT_NS = 2000000;

  localparam logic [62:0] HOST_MAX  = {63{1'b1}};
  localparam logic [31:0] TICKS_MAX = {32{1'b1}};

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_kind = 1'b0;
  logic [TICK_W-1:0]            in_hub_ticks = '0;
  logic [HOST_W-1:0]            in_host_time_ns = '0;
  logic                         in_reset_offset = 1'b0;

  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [TS_W-1:0]       out_timestamp_ns;

  // idle chances in percent, changed per traffic phase
  int send_idle_pct = 27;
  int recv_idle_pct = 79;
  // set by a test to start a hold-off, consumed by the receiver process
  int hold_request = 0;
  int hold_left = 0;

  int err_count = 0;

  // timestamps still owed by the block, oldest first
  logic [63:0] pending_ts[$];
  logic [63:0] want_ts;

  // shadow copy of the configuration registers
  logic [RES_W-1:0]    res_ns;
  logic [SLEW_W-1:0]   slew_ns;
  logic [MARGIN_W-1:0] margin;

  // shadow copy of the sync state
  logic        hts_synced;
  logic [31:0] anchor_ticks;
  logic [63:0] offset_now;
  logic [63:0] offset_goal;

  hub_timestamp_offset_slew u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_hub_ticks     (in_hub_ticks),
    .in_host_time_ns  (in_host_time_ns),
    .in_reset_offset  (in_reset_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_timestamp_ns (out_timestamp_ns)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // offset moved from offset_now toward offset_goal by whole elapsed ms
  function automatic logic [63:0] slewed_offset(input logic [31:0] ticks);
    longint      lag;
    longint      span_ns;
    longint      whole_ms;
    longint      cur;
    longint      goal;
    longint      cand;
    logic [63:0] step;
    // signed 33-bit tick difference, exact in 64 bits
    lag      = longint'({32'd0, ticks}) - longint'({32'd0, anchor_ticks});
    span_ns  = lag * longint'({44'd0, res_ns});
    // signed divide truncates toward zero
    whole_ms = span_ns / longint'({44'd0, NS_PER_MS});
    step     = $unsigned(whole_ms) * {44'd0, slew_ns};
    cur      = longint'(offset_now);
    goal     = longint'(offset_goal);
    if (goal >= cur) begin
      // compare the wrapped value, so an overflowing step clamps to cur
      cand = longint'(offset_now + step);
      if (cand > goal)
        cand = goal;
      else if (cand < cur)
        cand = cur;
    end else begin
      cand = longint'(offset_now - step);
      if (cand < goal)
        cand = goal;
      else if (cand > cur)
        cand = cur;
    end
    return $unsigned(cand);
  endfunction

  // advance the shadow state by one item; returns 1 when a timestamp is due
  function automatic bit predict_item(input item_kind_e kind, input logic [31:0] ticks,
                                      input logic [62:0] host, input logic jump,
                                      output logic [63:0] ts);
    logic [63:0] hub_ns;
    logic [63:0] goal;
    logic [63:0] kept;
    hub_ns = {32'd0, ticks} * {44'd0, res_ns};
    ts     = '0;
    if (kind == KIND_CONVERT) begin
      if (hts_synced)
        ts = hub_ns + slewed_offset(ticks);
      else
        ts = {1'b0, host} - {34'd0, margin};
      return 1'b1;
    end
    // sync: new target, offset either jumps or keeps its slewed value
    goal        = {1'b0, host} - hub_ns - {34'd0, margin};
    kept        = slewed_offset(ticks);
    offset_goal = goal;
    offset_now  = (!hts_synced || jump) ? goal : kept;
    anchor_ticks = ticks;
    hts_synced  = (host != '0);
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RESOLUTION: res_ns = data[RES_W-1:0];
      REG_SLEW:       slew_ns = data[SLEW_W-1:0];
      REG_MARGIN:     margin = data[MARGIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one item, with random idle cycles in front of it
  task automatic send_item(input item_kind_e kind, input logic [31:0] ticks,
                           input logic [62:0] host, input logic jump);
    logic [63:0] ts;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_hub_ticks    <= ticks;
    in_host_time_ns <= host;
    in_reset_offset <= jump;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted on this edge: update the shadow state in order
    if (predict_item(kind, ticks, host, jump, ts))
      pending_ts.push_back(ts);
  endtask

  // drop valid, let every owed result arrive, then let a sync finish
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_ts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, or a counted hold-off when a test asks for one
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_ts.size() == 0) begin
        report_mismatch($sformatf("unexpected result timestamp_ns %0d", out_timestamp_ns));
      end else begin
        want_ts = pending_ts.pop_front();
        if (out_timestamp_ns !== want_ts)
          report_mismatch($sformatf("timestamp_ns got %0d want %0d",
                                    out_timestamp_ns, $signed(want_ts)));
      end
    end
  end

  function automatic logic [62:0] rand_host();
    return 63'({$urandom, $urandom});
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // before any sync a convert gives host minus margin, wrapping below zero
  task automatic test_unsynced_convert();
    send_item(KIND_CONVERT, 32'd0, 63'd0, 1'b0);
    send_item(KIND_CONVERT, TICKS_MAX, HOST_MAX, 1'b1);
    // sync with host zero leaves the block unsynced
    send_item(KIND_SYNC, 32'd12345, 63'd0, 1'b0);
    send_item(KIND_CONVERT, 32'd77, 63'd5000000000, 1'b0);
    wait_idle();
  endtask

  // first sync jumps, later syncs slew up and down with clamping
  task automatic test_sync_and_slew();
    send_item(KIND_SYNC, 32'd1000, 63'd10000000000, 1'b0);
    send_item(KIND_CONVERT, 32'd1000, 63'd0, 1'b0);
    send_item(KIND_CONVERT, 32'd1500, 63'd0, 1'b0);
    // ticks before the sync point hold the offset
    send_item(KIND_CONVERT, 32'd900, 63'd0, 1'b0);
    // target 3 ms higher than the current offset
    send_item(KIND_SYNC, 32'd1500, 63'd10053000000, 1'b0);
    send_item(KIND_CONVERT, 32'd1510, 63'd0, 1'b0);
    send_item(KIND_CONVERT, 32'd1600, 63'd0, 1'b0);
    send_item(KIND_CONVERT, 32'd3000, 63'd0, 1'b0);
    send_item(KIND_CONVERT, 32'd1400, 63'd0, 1'b0);
    // forced jump, then a target 4 ms lower to slew downward
    send_item(KIND_SYNC, 32'd3000, 63'd10195000000, 1'b1);
    send_item(KIND_SYNC, 32'd3000, 63'd10191000000, 1'b0);
    send_item(KIND_CONVERT, 32'd3010, 63'd0, 1'b0);
    send_item(KIND_CONVERT, 32'd3100, 63'd0, 1'b0);
    wait_idle();
  endtask

  // widest registers and extreme fields: candidate offsets wrap at 64 bits
  task automatic test_wrap_extremes();
    write_reg(REG_MARGIN, '0);
    write_reg(REG_RESOLUTION, CFG_DATA_W'({RES_W{1'b1}}));
    write_reg(REG_SLEW, CFG_DATA_W'({SLEW_W{1'b1}}));
    send_item(KIND_SYNC, 32'd0, HOST_MAX, 1'b1);
    send_item(KIND_SYNC, 32'd0, HOST_MAX, 1'b0);
    // offset near the signed maximum plus a huge step wraps negative
    send_item(KIND_CONVERT, TICKS_MAX, HOST_MAX, 1'b0);
    // large negative target, then a sync far behind it in ticks
    send_item(KIND_SYNC, TICKS_MAX, 63'd1, 1'b1);
    send_item(KIND_SYNC, 32'd0, 63'd1, 1'b0);
    send_item(KIND_CONVERT, 32'h8000_0000, 63'd0, 1'b1);
    wait_idle();
  endtask

  // zero resolution makes hub time vanish; unused index must be ignored
  task automatic test_zero_resolution();
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    write_reg(REG_RESOLUTION, '0);
    write_reg(REG_SLEW, '0);
    write_reg(REG_MARGIN, {CFG_DATA_W{1'b1}});
    send_item(KIND_SYNC, $urandom, 63'd0, 1'b0);
    send_item(KIND_CONVERT, 32'd5, 63'd0, 1'b0);
    send_item(KIND_SYNC, $urandom, 63'd7, 1'b0);
    send_item(KIND_CONVERT, $urandom, rand_host(), 1'b0);
    wait_idle();
  endtask

  // pick a fresh register setting, extremes now and then
  task automatic random_config();
    logic [RES_W-1:0]    r;
    logic [SLEW_W-1:0]   s;
    logic [MARGIN_W-1:0] m;
    logic [9:0]          junk;
    case ($urandom_range(9))
      0:       r = '0;
      1:       r = 20'd1;
      2:       r = 20'd1000000;
      3:       r = {RES_W{1'b1}};
      4, 5:    r = RESET_RESOLUTION;
      default: r = RES_W'($urandom_range(1, 1000000));
    endcase
    case ($urandom_range(9))
      0:       s = '0;
      1:       s = 20'd1000000;
      2:       s = {SLEW_W{1'b1}};
      3, 4:    s = RESET_SLEW;
      5:       s = SLEW_W'($urandom_range(0, 1000));
      default: s = SLEW_W'($urandom_range(0, 1000000));
    endcase
    case ($urandom_range(7))
      0:       m = '0;
      1:       m = {MARGIN_W{1'b1}};
      2:       m = 30'd1000000000;
      3:       m = RESET_MARGIN;
      default: m = MARGIN_W'($urandom_range(0, 1000000000));
    endcase
    // bits above a 20-bit register are don't-care on the port
    junk = ($urandom_range(7) == 0) ? 10'($urandom) : 10'd0;
    write_reg(REG_RESOLUTION, {junk, r});
    junk = ($urandom_range(7) == 0) ? 10'($urandom) : 10'd0;
    write_reg(REG_SLEW, {junk, s});
    write_reg(REG_MARGIN, m);
    if ($urandom_range(5) == 0)
      write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  // mostly plausible clock traffic: host time tracks hub ticks with jitter, so
  // successive targets differ a little and the slew is only partly clamped;
  // the rest is raw noise across every field
  task automatic run_traffic(input int n_items, input bit with_hold);
    logic [62:0]  base_host;
    logic [62:0]  host;
    logic [31:0]  cursor;
    logic [31:0]  sync_at;
    logic [31:0]  ticks;
    int unsigned  span;
    int unsigned  jitter_amp;
    int unsigned  pick;
    longint       jitter;
    base_host = rand_host() >> $urandom_range(0, 16);
    cursor    = $urandom;
    sync_at   = cursor;
    case ($urandom_range(2))
      0:       span = 100;
      1:       span = 20000;
      default: span = 3000000;
    endcase
    case ($urandom_range(2))
      0:       jitter_amp = 1000;
      1:       jitter_amp = 1000000;
      default: jitter_amp = 500000000;
    endcase
    for (int i = 0; i < n_items; i++) begin
      // stall the receiver while the sender keeps pushing
      if (with_hold && i == n_items / 2)
        hold_request = HOLD_CYCLES;
      pick = $urandom_range(99);
      if (pick < 20) begin
        host = ($urandom_range(7) == 0) ? 63'd0 : rand_host();
        send_item(item_kind_e'($urandom_range(1)), $urandom, host, 1'($urandom));
      end else if (pick < 35) begin
        cursor  = cursor + $urandom_range(span);
        sync_at = cursor;
        jitter  = longint'($urandom_range(2 * jitter_amp)) - longint'(jitter_amp);
        host    = base_host + 63'(cursor) * 63'(res_ns) + 63'(jitter);
        send_item(KIND_SYNC, cursor, host, $urandom_range(9) == 0);
      end else begin
        // a few converts land before the sync point
        if ($urandom_range(9) == 0)
          ticks = sync_at - $urandom_range(2000);
        else
          ticks = sync_at + $urandom_range(span);
        host = base_host + 63'(ticks) * 63'(res_ns);
        send_item(KIND_CONVERT, ticks, host, 1'($urandom));
      end
    end
  endtask

  // one idling pattern, several register settings in turn
  task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                     input bit with_hold);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int seg = 0; seg < 4; seg++) begin
      wait_idle();
      random_config();
      run_traffic(130, with_hold && seg == 1);
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    res_ns       = RESET_RESOLUTION;
    slew_ns      = RESET_SLEW;
    margin       = RESET_MARGIN;
    hts_synced   = 1'b0;
    anchor_ticks = '0;
    offset_now   = '0;
    offset_goal  = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // directed checks run first, the first two on the reset configuration
    test_unsynced_convert();
    test_sync_and_slew();
    test_wrap_extremes();
    test_zero_resolution();

    test_random_traffic(27, 79, 1'b0);
    test_random_traffic(79, 27, 1'b1);
    test_random_traffic(0, 0, 1'b1);

    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
